// ===== src/llhp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llhp_pkg: shared types and constants of the latency histogram
// opcodes, controller states, bucket geometry and bucket bound function
// ----------------------------------------------------------------------------
package llhp_pkg;

    localparam int NUM_BUCKETS = 64;
    localparam int BKT_W       = 6;
    localparam int LAT_W       = 64;
    localparam int OUT_CNT_W   = 32;
    localparam int NUM_PCT     = 3;

    // percentile points, in percent
    localparam int PCT_K [NUM_PCT] = '{50, 90, 99};
    localparam int PCT_SCALE       = 100;

    typedef enum logic {
        OP_OBSERVE = 1'b0,
        OP_DRAIN   = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_SETUP,
        ST_WALK,
        ST_TAIL,
        ST_DONE
    } t_state;

    // bucket read request from the bit length encoder
    typedef struct packed {
        logic             vld;
        logic [BKT_W-1:0] bkt;
    } t_bkt_req;

    // upper bound of a bucket: 2^i - 1, all ones for the top bucket
    function automatic logic [LAT_W-1:0] f_bucket_bound(input logic [BKT_W-1:0] idx);
        logic [LAT_W-1:0] bound;
        if (idx == BKT_W'(NUM_BUCKETS - 1)) begin
            bound = '1;
        end else begin
            bound = ~({LAT_W{1'b1}} << idx);
        end
        return bound;
    endfunction

endpackage

// ===== src/llhp_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llhp channel interfaces
// valid/ready channels for sample beats in and percentile report beats out
// ----------------------------------------------------------------------------
interface llhp_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [63:0] latency_ns;

    modport source (output valid, output opcode, output latency_ns, input ready);
    modport sink   (input valid, input opcode, input latency_ns, output ready);
endinterface

interface llhp_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] p50_ns;
    logic [63:0] p90_ns;
    logic [63:0] p99_ns;
    logic [63:0] window_max_ns;
    logic [31:0] sample_count;

    modport source (output valid, output p50_ns, output p90_ns, output p99_ns,
                    output window_max_ns, output sample_count, input ready);
    modport sink   (input valid, input p50_ns, input p90_ns, input p99_ns,
                    input window_max_ns, input sample_count, output ready);
endinterface

// ===== src/llhp_bit_len.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llhp_bit_len: pipelined bit length encoder
// byte-wise leading one search, registered, then merged into a bucket index
// ----------------------------------------------------------------------------
module llhp_bit_len (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vld,
    input  logic [llhp_pkg::LAT_W-1:0]          i_lat,
    output llhp_pkg::t_bkt_req                  o_req
);

    localparam int NGRP = llhp_pkg::LAT_W / 8;

    logic            r_vld;
    logic [NGRP-1:0] r_any;
    logic [2:0]      r_pos [NGRP];
    logic [NGRP-1:0] n_any;
    logic [2:0]      n_pos [NGRP];
    logic [6:0]      len;

    // per byte: any bit set, and position of the top set bit
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_any[g] = |i_lat[8*g +: 8];
            n_pos[g] = '0;
            for (int b = 0; b < 8; b++) begin
                if (i_lat[8*g + b]) begin
                    n_pos[g] = 3'(b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_any <= n_any;
        r_pos <= n_pos;
    end

    // highest nonzero byte wins
    always_comb begin
        len = '0;
        for (int g = 0; g < NGRP; g++) begin
            if (r_any[g]) begin
                len = 7'(g * 8) + 7'(r_pos[g]) + 7'd1;
            end
        end
    end

    assign o_req.vld = r_vld;
    assign o_req.bkt = (len > 7'(llhp_pkg::NUM_BUCKETS - 1))
                     ? llhp_pkg::BKT_W'(llhp_pkg::NUM_BUCKETS - 1)
                     : len[llhp_pkg::BKT_W-1:0];

endmodule

// ===== src/log2_latency_histogram_percentiles.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log2_latency_histogram_percentiles: log2 bucket latency monitor
// files latency samples into 64 log2 buckets held in a memory with one read
// port and one write port, and on drain walks the buckets to report p50, p90,
// p99, max and count
//
//  channel  dir  beat                          handshake
//  -------  ---  ----------------------------  ----------------------------
//  i_in     in   opcode, latency_ns            valid/ready, ready in idle
//  o_out    out  p50/p90/p99, max, count       valid/ready, output register
//
//  observe beats are taken one per clock while idle; each one updates count and
//  max at accept and its bucket counter through the encoder, read, increment
//  and write steps; a drain beat runs a flush of the observe pipe, a setup step,
//  a walk over all 64 buckets through the memory read port, a tail that empties
//  walk stages a, b and c, then the report load; no beat is taken meanwhile
//  reset needs no clearing pass: per-bucket valid bits read unwritten
//  entries as zero and are cleared again at the end of every drain
//  a stalled report holds only the report load of the next drain, and no
//  beat is taken while that load waits; until then observes continue
// ----------------------------------------------------------------------------
module log2_latency_histogram_percentiles #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    llhp_in_if.sink           i_in,
    llhp_out_if.source        o_out
);

    localparam int CW   = COUNT_WIDTH;
    localparam int NB   = llhp_pkg::NUM_BUCKETS;
    localparam int BW   = llhp_pkg::BKT_W;
    localparam int LW   = llhp_pkg::LAT_W;
    localparam int NP   = llhp_pkg::NUM_PCT;
    localparam int OCW  = llhp_pkg::OUT_CNT_W;
    // running bucket sum: up to NB counts of CW bits
    localparam int RW   = CW + BW;
    // (n + 1) * k with k below 128
    localparam int TW   = CW + 8;
    // 100 * run + 99
    localparam int SW   = RW + 7;
    localparam int NW   = (CW > OCW) ? CW : OCW;

    // ---------------------------------------------------------------- control
    llhp_pkg::t_state r_state;
    llhp_pkg::t_state n_state;

    logic in_rdy;
    logic walk_rd;
    logic do_setup;
    logic load_out;
    logic in_acc;
    logic obs_acc;
    logic drn_acc;

    // ------------------------------------------------------------ window state
    logic [CW-1:0] r_total;
    logic [LW-1:0] r_max;
    logic [CW-1:0] r_n;        // snapshot for the drain
    logic [LW-1:0] r_mx;

    // ------------------------------------------------------------------ memory
    logic [CW-1:0] r_mem [NB];
    logic [CW-1:0] r_rdata;
    logic [BW-1:0] mem_ra;
    logic [NB-1:0] r_bvld;

    // ---------------------------------------------------------- observe pipe
    llhp_pkg::t_bkt_req enc_req;
    logic          r_s3_vld;
    logic [BW-1:0] r_s3_bkt;
    logic          r_fwd_vld;
    logic [BW-1:0] r_fwd_bkt;
    logic [CW-1:0] r_fwd_data;
    logic [CW-1:0] s3_cnt;
    logic [CW-1:0] s3_next;

    // ------------------------------------------------------------- walk pipe
    logic [BW-1:0] r_walk_addr;
    logic          r_wa_vld;
    logic [BW-1:0] r_wa_idx;
    logic          r_wb_vld;
    logic [BW-1:0] r_wb_idx;
    logic          r_wc_vld;
    logic [RW-1:0] r_run;
    logic [SW-1:0] r_scaled;
    logic [LW-1:0] r_val;
    logic [TW-1:0] r_thr   [NP];
    logic [LW-1:0] r_pct   [NP];
    logic [NP-1:0] r_found;
    logic [CW-1:0] wa_cnt;
    logic [LW-1:0] wb_bound;
    logic [CW:0]   np1;

    // ---------------------------------------------------------------- report
    logic          r_out_vld;
    logic [LW-1:0] r_out_p50;
    logic [LW-1:0] r_out_p90;
    logic [LW-1:0] r_out_p99;
    logic [LW-1:0] r_out_max;
    logic [OCW-1:0] r_out_cnt;
    logic [LW-1:0] fin_pct [NP];
    logic [NW-1:0] n_ext;

    // ---------------------------------------------------------- state machine
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            llhp_pkg::ST_IDLE: begin
                if (drn_acc) begin
                    n_state = llhp_pkg::ST_FLUSH;
                end
            end
            llhp_pkg::ST_FLUSH: begin
                // wait for in-flight bucket updates to land
                if (!enc_req.vld && !r_s3_vld) begin
                    n_state = llhp_pkg::ST_SETUP;
                end
            end
            llhp_pkg::ST_SETUP: begin
                n_state = llhp_pkg::ST_WALK;
            end
            llhp_pkg::ST_WALK: begin
                if (r_walk_addr == BW'(NB - 1)) begin
                    n_state = llhp_pkg::ST_TAIL;
                end
            end
            llhp_pkg::ST_TAIL: begin
                if (!r_wa_vld && !r_wb_vld && !r_wc_vld) begin
                    n_state = llhp_pkg::ST_DONE;
                end
            end
            llhp_pkg::ST_DONE: begin
                if (!r_out_vld || o_out.ready) begin
                    n_state = llhp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = llhp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_rdy   = 1'b0;
        walk_rd  = 1'b0;
        do_setup = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            llhp_pkg::ST_IDLE:  in_rdy   = 1'b1;
            llhp_pkg::ST_SETUP: do_setup = 1'b1;
            llhp_pkg::ST_WALK:  walk_rd  = 1'b1;
            llhp_pkg::ST_DONE:  load_out = !r_out_vld || o_out.ready;
            default: begin
                in_rdy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= llhp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign i_in.ready = in_rdy;
    assign in_acc     = i_in.valid && in_rdy;
    assign obs_acc    = in_acc && (i_in.opcode == llhp_pkg::OP_OBSERVE);
    assign drn_acc    = in_acc && (i_in.opcode == llhp_pkg::OP_DRAIN);

    // ----------------------------------------------------- count and maximum
    // updated at accept; a drain snapshots them and opens a new window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_max   <= '0;
        end else if (drn_acc) begin
            r_total <= '0;
            r_max   <= '0;
        end else if (obs_acc) begin
            if (r_total != '1) begin
                r_total <= r_total + CW'(1);
            end
            if (i_in.latency_ns > r_max) begin
                r_max <= i_in.latency_ns;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (drn_acc) begin
            r_n  <= r_total;
            r_mx <= r_max;
        end
    end

    // -------------------------------------------------------- bucket encoder
    llhp_bit_len u_bit_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (obs_acc),
        .i_lat   (i_in.latency_ns),
        .o_req   (enc_req)
    );

    // ---------------------------------------------------------- bucket memory
    // one read port shared by observe lookups and the drain walk
    assign mem_ra = walk_rd ? r_walk_addr : enc_req.bkt;

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[mem_ra];
        if (r_s3_vld) begin
            r_mem[r_s3_bkt] <= s3_next;
        end
    end

    // unwritten buckets read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bvld <= '0;
        end else if (load_out) begin
            r_bvld <= '0;
        end else if (r_s3_vld) begin
            r_bvld[r_s3_bkt] <= 1'b1;
        end
    end

    // ------------------------------------------------ read-modify-write stage
    // a read issued in the same clock as the previous write misses it,
    // so that write is forwarded
    always_comb begin
        if (r_fwd_vld && (r_fwd_bkt == r_s3_bkt)) begin
            s3_cnt = r_fwd_data;
        end else if (r_bvld[r_s3_bkt]) begin
            s3_cnt = r_rdata;
        end else begin
            s3_cnt = '0;
        end
        s3_next = (s3_cnt == '1) ? s3_cnt : s3_cnt + CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld  <= 1'b0;
            r_fwd_vld <= 1'b0;
        end else begin
            r_s3_vld  <= enc_req.vld;
            r_fwd_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_bkt   <= enc_req.bkt;
        r_fwd_bkt  <= r_s3_bkt;
        r_fwd_data <= s3_next;
    end

    // ------------------------------------------------------------ drain walk
    // rank test without a divider:
    // run >= floor((n+1)*k/100)  <=>  100*run + 99 >= (n+1)*k
    assign np1 = (CW + 1)'(r_n) + (CW + 1)'(1);

    always_ff @(posedge i_clk) begin
        if (do_setup) begin
            for (int k = 0; k < NP; k++) begin
                r_thr[k] <= TW'(np1) * TW'(llhp_pkg::PCT_K[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk_addr <= '0;
            r_wa_vld    <= 1'b0;
            r_wb_vld    <= 1'b0;
            r_wc_vld    <= 1'b0;
        end else begin
            if (do_setup) begin
                r_walk_addr <= '0;
            end else if (walk_rd) begin
                r_walk_addr <= r_walk_addr + BW'(1);
            end
            r_wa_vld <= walk_rd;
            r_wb_vld <= r_wa_vld;
            r_wc_vld <= r_wb_vld;
        end
    end

    // stage a: accumulate the bucket just read
    assign wa_cnt = r_bvld[r_wa_idx] ? r_rdata : '0;

    always_ff @(posedge i_clk) begin
        r_wa_idx <= r_walk_addr;
        r_wb_idx <= r_wa_idx;
        if (do_setup) begin
            r_run <= '0;
        end else if (r_wa_vld) begin
            r_run <= r_run + RW'(wa_cnt);
        end
    end

    // stage b: scale the running sum, bucket bound capped at the maximum
    assign wb_bound = llhp_pkg::f_bucket_bound(r_wb_idx);

    always_ff @(posedge i_clk) begin
        r_scaled <= SW'(r_run) * SW'(llhp_pkg::PCT_SCALE) + SW'(llhp_pkg::PCT_SCALE - 1);
        r_val    <= (wb_bound < r_mx) ? wb_bound : r_mx;
    end

    // stage c: first bucket that reaches each rank
    always_ff @(posedge i_clk) begin
        if (do_setup) begin
            r_found <= '0;
        end else if (r_wc_vld) begin
            for (int k = 0; k < NP; k++) begin
                if (!r_found[k] && (r_scaled >= SW'(r_thr[k]))) begin
                    r_found[k] <= 1'b1;
                    r_pct[k]   <= r_val;
                end
            end
        end
    end

    // ----------------------------------------------------------------- report
    always_comb begin
        for (int k = 0; k < NP; k++) begin
            if (r_n == '0) begin
                fin_pct[k] = '0;
            end else if (r_found[k]) begin
                fin_pct[k] = r_pct[k];
            end else begin
                fin_pct[k] = r_mx;
            end
        end
    end

    assign n_ext = NW'(r_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load_out) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_p50 <= fin_pct[0];
            r_out_p90 <= fin_pct[1];
            r_out_p99 <= fin_pct[2];
            r_out_max <= r_mx;
            // report count saturates at the port width
            r_out_cnt <= (n_ext > NW'({OCW{1'b1}})) ? '1 : n_ext[OCW-1:0];
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.p50_ns        = r_out_p50;
    assign o_out.p90_ns        = r_out_p90;
    assign o_out.p99_ns        = r_out_p99;
    assign o_out.window_max_ns = r_out_max;
    assign o_out.sample_count  = r_out_cnt;

endmodule
